// ===== hdl/aole_pkg.sv =====
// ----------------------------------------------------------------------------
// aole_pkg: shared types and codes for the arrival order list engine
// Request and result payloads, action and status codes, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package aole_pkg;

    localparam int AOLE_CAPACITY = 16;

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_DUMP   = 2'd2;

    localparam logic [2:0] ST_APPENDED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_DUMP      = 3'd5;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
    } aole_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] entry_value;
        logic               last;
    } aole_out_t;

    typedef struct packed {
        logic capture;    // latch request, snapshot match vector
        logic exec;       // apply append/remove, emit single result
        logic dump_step;  // emit head entry and rotate list
    } aole_cmd_t;

    typedef struct packed {
        logic empty;
        logic dump_last;
        logic out_free;
    } aole_sts_t;

endpackage

// ===== hdl/aole_ctrl.sv =====
// ----------------------------------------------------------------------------
// aole_ctrl: request sequencer
// Accepts a request, then issues one execute step or a run of dump steps
// (none for an unused action code), each only when the result register can take a new result.
// ----------------------------------------------------------------------------
module aole_ctrl
    import aole_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_action,
    output logic       s_ready,
    input  aole_sts_t  sts,
    output aole_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        cmd.capture   = 1'b0;
        cmd.exec      = 1'b0;
        cmd.dump_step = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    case (s_action)
                        ACT_APPEND: state_next = S_EXEC;
                        ACT_REMOVE: state_next = S_EXEC;
                        ACT_DUMP:   state_next = sts.empty ? S_EXEC : S_DUMP;
                        default:    state_next = S_IDLE;  // unused code: no result
                    endcase
                end
            end
            S_EXEC: begin
                if (sts.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUMP: begin
                if (sts.out_free) begin
                    cmd.dump_step = 1'b1;
                    if (sts.dump_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/aole_dpath.sv =====
// ----------------------------------------------------------------------------
// aole_dpath: list cells, occupancy and result register
// Cells form a shift row: remove closes the gap with a masked shift, dump
// rotates the occupied cells through the head one step per result.
// ----------------------------------------------------------------------------
module aole_dpath
    import aole_pkg::*;
#(
    parameter int CAPACITY = AOLE_CAPACITY
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  aole_in_t  s_data,
    input  aole_cmd_t cmd,
    output aole_sts_t sts,
    output logic      m_valid,
    input  logic      m_ready,
    output aole_out_t m_data
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic signed [31:0] cells_reg [CAPACITY];
    logic signed [31:0] cells_next [CAPACITY];
    logic signed [31:0] cells_up [CAPACITY];
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [CAPACITY-1:0] match_reg, match_next;
    logic [CAPACITY-1:0] shift_en;
    logic [1:0]         req_action_reg;
    logic signed [31:0] req_value_reg;
    logic [IDX_W-1:0]   dump_cnt_reg, dump_cnt_next;
    logic               m_valid_reg, m_valid_next;
    aole_out_t          m_data_reg, m_data_next;
    logic               full;
    logic               found;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_up
            if (g < CAPACITY - 1) begin : g_mid
                assign cells_up[g] = cells_reg[g + 1];
            end else begin : g_end
                assign cells_up[g] = cells_reg[g];
            end
        end
    endgenerate

    assign full  = (occ_reg == OCC_W'(CAPACITY));
    assign found = |match_reg;

    assign sts.empty     = (occ_reg == '0);
    assign sts.dump_last = ((OCC_W'(dump_cnt_reg) + OCC_W'(1)) == occ_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match_next[i] = (cells_reg[i] == s_data.value) && (OCC_W'(i) < occ_reg);
            // shift every cell at or behind the first match
            shift_en[i]   = |(match_reg & ~({CAPACITY{1'b1}} << (i + 1)));
        end
    end

    always_comb begin
        occ_next      = occ_reg;
        dump_cnt_next = dump_cnt_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        for (int i = 0; i < CAPACITY; i++) begin
            cells_next[i] = cells_reg[i];
        end

        if (cmd.capture) begin
            dump_cnt_next = '0;
        end

        if (cmd.exec) begin
            m_valid_next           = 1'b1;
            m_data_next.last       = 1'b1;
            m_data_next.entry_value = req_value_reg;
            case (req_action_reg)
                ACT_APPEND: begin
                    if (full) begin
                        m_data_next.status = ST_FULL;
                    end else begin
                        m_data_next.status = ST_APPENDED;
                        occ_next           = occ_reg + OCC_W'(1);
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (occ_reg == OCC_W'(i)) begin
                                cells_next[i] = req_value_reg;
                            end
                        end
                    end
                end
                ACT_REMOVE: begin
                    if (sts.empty) begin
                        m_data_next.status = ST_EMPTY;
                    end else if (!found) begin
                        m_data_next.status = ST_NOT_FOUND;
                    end else begin
                        m_data_next.status = ST_REMOVED;
                        occ_next           = occ_reg - OCC_W'(1);
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (shift_en[i]) begin
                                cells_next[i] = cells_up[i];
                            end
                        end
                    end
                end
                default: begin
                    // empty dump
                    m_data_next.status      = ST_EMPTY;
                    m_data_next.entry_value = '0;
                end
            endcase
        end

        if (cmd.dump_step) begin
            m_valid_next            = 1'b1;
            m_data_next.status      = ST_DUMP;
            m_data_next.entry_value = cells_reg[0];
            m_data_next.last        = sts.dump_last;
            dump_cnt_next           = dump_cnt_reg + IDX_W'(1);
            // rotate occupied cells: head wraps to the tail slot
            for (int i = 0; i < CAPACITY; i++) begin
                if (OCC_W'(i + 1) == occ_reg) begin
                    cells_next[i] = cells_reg[0];
                end else begin
                    cells_next[i] = cells_up[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            cells_reg[i] <= cells_next[i];
        end
        dump_cnt_reg <= dump_cnt_next;
        m_data_reg   <= m_data_next;
        if (cmd.capture) begin
            req_action_reg <= s_data.action;
            req_value_reg  <= s_data.value;
            match_reg      <= match_next;
        end
    end

endmodule

// ===== hdl/arrival_order_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// arrival_order_list_engine_unit: bounded arrival-order list
// Append/remove: the request is latched at acceptance, and the execute step then
// writes the result; no new request is taken until that step is done.
// Dump: one result per cycle from the cell row while the result register is free.
// Result stalls hold each step until the result register is free.
// Reset: aresetn sync low clears occupancy and result valid; cells undefined.
// ----------------------------------------------------------------------------
module arrival_order_list_engine_unit
    import aole_pkg::*;
#(
    parameter int CAPACITY = AOLE_CAPACITY
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  aole_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output aole_out_t m_data
);

    aole_cmd_t cmd;
    aole_sts_t sts;

    aole_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_data.action),
        .s_ready  (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    aole_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== sim/aole_result_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aole_result_monitor: result checker for the arrival order list engine
// Watches both channels, keeps its own copy of the list, predicts the
// results of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module aole_result_monitor
    import aole_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  aole_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  aole_out_t m_data,
    output int        error_count,
    output int        outstanding
);

    localparam int PRINT_LIMIT = 40;

    logic signed [31:0] list_cells [AOLE_CAPACITY];
    int                 list_count = 0;
    aole_out_t          expected_results [$];
    int                 fail_count = 0;
    int                 pending = 0;
    int                 result_index = 0;

    assign error_count = fail_count;
    assign outstanding = pending;

    task automatic report_error(input string msg);
        if (fail_count < PRINT_LIMIT) begin
            $display("%0t ns ERROR: %s", $time, msg);
        end
        fail_count++;
    endtask

    task automatic queue_result(input logic [2:0] status, input logic signed [31:0] val,
                                input logic last);
        aole_out_t r;
        r.status      = status;
        r.entry_value = val;
        r.last        = last;
        expected_results.push_back(r);
    endtask

    // Update the list copy for one accepted request and queue its results
    task automatic apply_list_request(input aole_in_t req);
        int hit;
        int i;
        hit = -1;
        case (req.action)
            ACT_APPEND: begin
                if (list_count >= AOLE_CAPACITY) begin
                    queue_result(ST_FULL, req.value, 1'b1);
                end else begin
                    list_cells[list_count] = req.value;
                    list_count++;
                    queue_result(ST_APPENDED, req.value, 1'b1);
                end
            end
            ACT_REMOVE: begin
                if (list_count == 0) begin
                    queue_result(ST_EMPTY, req.value, 1'b1);
                end else begin
                    for (i = 0; i < list_count; i++) begin
                        if (hit < 0 && list_cells[i] == req.value) begin
                            hit = i;
                        end
                    end
                    if (hit < 0) begin
                        queue_result(ST_NOT_FOUND, req.value, 1'b1);
                    end else begin
                        // entries behind the hit close up toward the head
                        for (i = hit; i + 1 < list_count; i++) begin
                            list_cells[i] = list_cells[i + 1];
                        end
                        list_count--;
                        queue_result(ST_REMOVED, req.value, 1'b1);
                    end
                end
            end
            ACT_DUMP: begin
                if (list_count == 0) begin
                    queue_result(ST_EMPTY, 32'sd0, 1'b1);
                end else begin
                    for (i = 0; i < list_count; i++) begin
                        queue_result(ST_DUMP, list_cells[i], (i + 1 == list_count));
                    end
                end
            end
            default: begin
                // unused action code: request is dropped without a result
            end
        endcase
    endtask

    task automatic check_result(input aole_out_t got);
        aole_out_t want;
        if (expected_results.size() == 0) begin
            report_error($sformatf("unexpected result status=%0d value=%0d last=%0b",
                                   got.status, got.entry_value, got.last));
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
            report_error($sformatf("result %0d status: expected %0d got %0d",
                                   result_index, want.status, got.status));
        end
        if (got.entry_value !== want.entry_value) begin
            report_error($sformatf("result %0d entry_value: expected %0d got %0d",
                                   result_index, want.entry_value, got.entry_value));
        end
        if (got.last !== want.last) begin
            report_error($sformatf("result %0d last: expected %0b got %0b",
                                   result_index, want.last, got.last));
        end
        result_index++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            list_count = 0;
            expected_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                apply_list_request(s_data);
            end
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== sim/arrival_order_list_engine_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arrival_order_list_engine_unit_tb: testbench for the arrival order list
// Directed requests cover empty, full, duplicate and unused-code cases, then
// random append/remove/dump traffic with bursty requests and result stalls.
// ----------------------------------------------------------------------------
module arrival_order_list_engine_unit_tb;
    import aole_pkg::*;

    localparam int         RANDOM_REQUESTS = 150;
    localparam int         IDLE_LIMIT      = 2000;
    localparam int         DRAIN_CYCLES    = 2 * AOLE_CAPACITY + 8;
    localparam logic [1:0] ACT_UNUSED      = 2'd3;

    // small pool so removes and duplicates hit often
    localparam logic signed [31:0] VALUE_POOL [0:7] = '{
        32'sd0, -32'sd1, 32'sd1, 32'sd42, -32'sd42,
        32'sh7FFFFFFF, 32'sh80000000, 32'sd1000
    };

    typedef enum {RDY_OPEN, RDY_RANDOM, RDY_HOLD, RDY_TOGGLE} ready_mode_t;
    typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED} traffic_mix_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    aole_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    aole_out_t m_data;
    int        error_count;
    int        outstanding;
    int        burst_left;

    arrival_order_list_engine_unit #(
        .CAPACITY (AOLE_CAPACITY)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    aole_result_monitor result_monitor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [1:0] act, input logic signed [31:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 20);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= '{action: act, value: val};
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 99) < 65) begin
            return VALUE_POOL[$urandom_range(0, 7)];
        end
        return $urandom;
    endfunction

    // Result-side stall pattern, independent of the request side
    initial begin
        ready_mode_t mode;
        int          span;
        m_ready = 1'b0;
        mode    = RDY_OPEN;
        span    = 0;
        forever begin
            @(negedge aclk);
            if (span == 0) begin
                mode = ready_mode_t'($urandom_range(0, 3));
                span = (mode == RDY_HOLD) ? $urandom_range(1, 8) : $urandom_range(4, 40);
            end
            span--;
            case (mode)
                RDY_OPEN:   m_ready <= 1'b1;
                RDY_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                RDY_HOLD:   m_ready <= 1'b0;
                default:    m_ready <= ~m_ready;
            endcase
        end
    end

    // Ends the run when neither channel moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge aresetn);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int           k;
        int           real_count;
        int           mix_left;
        int           roll;
        traffic_mix_t mix;
        logic [1:0]   act;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        burst_left = 0;
        real_count = 0;
        mix_left   = 0;
        mix        = MIX_BALANCED;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty list cases and the unused code
        send_request(ACT_DUMP, 32'sh5A5A5A5A);
        send_request(ACT_REMOVE, 32'sd7);
        send_request(ACT_UNUSED, -32'sd1);

        // fill to capacity: extremes first, duplicates in the middle, unique tail
        send_request(ACT_APPEND, 32'sh7FFFFFFF);
        send_request(ACT_APPEND, 32'sh80000000);
        send_request(ACT_APPEND, 32'sd0);
        send_request(ACT_APPEND, -32'sd1);
        for (k = 0; k < AOLE_CAPACITY - 5; k++) begin
            send_request(ACT_APPEND, (k % 4) + 3);
        end
        send_request(ACT_APPEND, 32'sd777);

        send_request(ACT_APPEND, 32'sd123);      // full, dropped
        send_request(ACT_DUMP, 32'sd0);
        send_request(ACT_REMOVE, 32'sd5);        // first of several matches
        send_request(ACT_REMOVE, 32'sd1000);     // no match
        send_request(ACT_REMOVE, 32'sh7FFFFFFF); // head
        send_request(ACT_REMOVE, 32'sd777);      // tail
        send_request(ACT_DUMP, -32'sd1);

        // random traffic with a drifting mix so the list swings full and empty
        while (real_count < RANDOM_REQUESTS) begin
            if (mix_left == 0) begin
                mix      = traffic_mix_t'($urandom_range(0, 2));
                mix_left = $urandom_range(8, 24);
            end
            mix_left--;
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                act = ACT_UNUSED;
            end else begin
                roll = $urandom_range(0, 99);
                case (mix)
                    MIX_GROW:   act = (roll < 70) ? ACT_APPEND :
                                      (roll < 88) ? ACT_REMOVE : ACT_DUMP;
                    MIX_SHRINK: act = (roll < 25) ? ACT_APPEND :
                                      (roll < 82) ? ACT_REMOVE : ACT_DUMP;
                    default:    act = (roll < 45) ? ACT_APPEND :
                                      (roll < 82) ? ACT_REMOVE : ACT_DUMP;
                endcase
                real_count++;
            end
            send_request(act, (act == ACT_DUMP) ? $urandom : pick_value());
        end
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
